// File: rtl/core/hrp_pkg.sv
// Shared constants, codes and the queued operation type of the hashed-token projection core.
package hrp_pkg;

    localparam int DIMS        = 3072;
    localparam int TOKEN_LIMIT = 256;

    localparam int ADDR_W  = $clog2(DIMS);
    localparam int CNT_W   = $clog2(DIMS + 1);
    localparam int LEN_W   = $clog2(TOKEN_LIMIT);
    localparam int INDEX_W = 12;
    localparam int ACC_W   = 24;
    localparam int HASH_W  = 64;
    localparam int VALUE_W = 18;
    localparam int NORM_W  = 48;
    localparam int SUM_W   = 58;
    localparam int SQ_W    = 2 * ACC_W - 1;
    localparam int ROOT_W  = 45;
    localparam int ROOT_STEPS = 45;
    localparam int Q_W     = 18;
    localparam int Q_MAX   = 65536;
    localparam int FOLD_W  = 28;
    localparam int FQ_W    = 17;
    localparam int RECIP_SHIFT = 38;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W  = $clog2(QUEUE_DEPTH);

    localparam logic [HASH_W-1:0] HASH_INIT = 64'd5381;
    localparam logic [31:0] DK_STEP = 32'd2654435761;
    localparam logic [31:0] MIX_C1  = 32'h85ebca6b;
    localparam logic [31:0] MIX_C2  = 32'hc2b2ae35;
    localparam int W_MOD    = 2000;
    localparam int W_OFFSET = 1000;
    // Residues of 2^16, 2^32 and 2^48 modulo the weight range.
    localparam int FOLD_1 = 1536;
    localparam int FOLD_2 = 1296;
    localparam int FOLD_3 = 656;
    localparam logic [FOLD_W-1:0] RECIP = 28'd137438953;

    localparam logic [1:0] CMD_TEXT   = 2'd0;
    localparam logic [1:0] CMD_FINISH = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ZERO  = 2'd1;
    localparam logic [1:0] ST_STALE = 2'd2;

    typedef enum logic [1:0] {
        OP_FLUSH  = 2'd0,
        OP_FINISH = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op_kind;

    typedef struct packed {
        t_op_kind            kind;
        logic [HASH_W-1:0]   hash;
        logic                has_token;
        logic                unfinish;
        logic [INDEX_W-1:0]  index;
    } t_op;

endpackage

// File: rtl/core/hrp_in_if.sv
// Input channel: command items with valid/ready handshake.
interface hrp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  text_byte;
    logic [11:0] element_index;

    modport source (output valid, output cmd, output text_byte, output element_index,
                    input ready);
    modport sink (input valid, input cmd, input text_byte, input element_index,
                  output ready);
endinterface

// File: rtl/core/hrp_out_if.sv
// Output channel: normalized element results with valid/ready handshake.
interface hrp_out_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] element_value;
    logic [1:0]         status;

    modport source (output valid, output element_value, output status, input ready);
    modport sink (input valid, input element_value, input status, output ready);
endinterface

// File: rtl/core/hrp_front.sv
// Front end: accepts bytes and commands, builds token hashes and queues work for the back end.
module hrp_front
    import hrp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    hrp_in_if.sink i_in,
    input  logic i_q_full,
    input  logic i_init_busy,
    output logic o_push,
    output t_op  o_op
);

    logic [HASH_W-1:0] r_hash, n_hash;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_dirty, n_dirty;
    logic              accept;
    logic              is_digit, is_upper, is_lower;
    logic [7:0]        lc;

    assign i_in.ready = !i_q_full && !i_init_busy;
    assign accept     = i_in.valid && i_in.ready;

    assign is_digit = (i_in.text_byte >= 8'h30) && (i_in.text_byte <= 8'h39);
    assign is_upper = (i_in.text_byte >= 8'h41) && (i_in.text_byte <= 8'h5a);
    assign is_lower = (i_in.text_byte >= 8'h61) && (i_in.text_byte <= 8'h7a);
    assign lc       = is_upper ? (i_in.text_byte + 8'd32) : i_in.text_byte;

    always_comb begin
        n_hash  = r_hash;
        n_len   = r_len;
        n_dirty = r_dirty;
        o_push  = 1'b0;
        o_op.kind      = OP_READ;
        o_op.hash      = r_hash;
        o_op.has_token = (r_len != '0);
        o_op.unfinish  = r_dirty;
        o_op.index     = i_in.element_index;
        if (accept) begin
            unique case (i_in.cmd)
                CMD_TEXT: begin
                    if (is_digit || is_upper || is_lower) begin
                        n_dirty = 1'b1;
                        if (r_len < LEN_W'(TOKEN_LIMIT - 1)) begin
                            n_hash = (r_hash << 5) + r_hash + {56'd0, lc};
                            n_len  = r_len + 1'b1;
                        end
                    end else if (r_len != '0) begin
                        // A separator ends the token; the flush also marks the vector stale.
                        o_push        = 1'b1;
                        o_op.kind     = OP_FLUSH;
                        o_op.unfinish = 1'b1;
                        n_hash  = HASH_INIT;
                        n_len   = '0;
                        n_dirty = 1'b0;
                    end else begin
                        n_dirty = 1'b1;
                    end
                end
                CMD_FINISH: begin
                    o_push    = 1'b1;
                    o_op.kind = OP_FINISH;
                    n_hash  = HASH_INIT;
                    n_len   = '0;
                    n_dirty = 1'b0;
                end
                CMD_READ: begin
                    o_push    = 1'b1;
                    o_op.kind = OP_READ;
                    n_dirty   = 1'b0;
                end
                CMD_CLEAR: begin
                    o_push    = 1'b1;
                    o_op.kind = OP_CLEAR;
                    n_hash  = HASH_INIT;
                    n_len   = '0;
                    n_dirty = 1'b0;
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash  <= HASH_INIT;
            r_len   <= '0;
            r_dirty <= 1'b0;
        end else begin
            r_hash  <= n_hash;
            r_len   <= n_len;
            r_dirty <= n_dirty;
        end
    end

endmodule

// File: rtl/core/hrp_fifo.sv
// Short operation queue between the front end and the back end.
module hrp_fifo
    import hrp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_pop,
    output t_op  o_op,
    output logic o_empty
);

    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_op    = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
        end
    end

endmodule

// File: rtl/core/hrp_back.sv
// Back end: accumulator memory, weight pipeline, norm and square root, and element division.
module hrp_back
    import hrp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_op  i_op,
    input  logic i_empty,
    output logic o_pop,
    output logic o_init_busy,
    hrp_out_if.source o_out
);

    typedef enum logic [8:0] {
        BS_CLEAR = 9'b000000001,
        BS_IDLE  = 9'b000000010,
        BS_FLUSH = 9'b000000100,
        BS_SUMSQ = 9'b000001000,
        BS_ROOT  = 9'b000010000,
        BS_RDMEM = 9'b000100000,
        BS_DIV   = 9'b001000000,
        BS_OUT   = 9'b010000000,
        BS_SPARE = 9'b100000000
    } t_bstate;

    localparam int D_W   = ACC_W + 33;
    localparam int DV_W  = NORM_W + Q_W - 1;
    localparam int CMP_W = NORM_W + Q_W;
    localparam int REM_W = ROOT_W + 2;
    localparam int RSH_W = REM_W + 2;

    t_bstate r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [31:0]       r_dk, n_dk;
    logic [HASH_W-1:0] r_hash, n_hash;
    logic              r_chain, n_chain;
    logic              r_finished, n_finished;
    logic [NORM_W-1:0] r_norm, n_norm;
    logic              r_init, n_init;
    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [SUM_W-1:0]  r_sh, n_sh;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [ROOT_W-1:0] r_root, n_root;
    logic [5:0]        r_step, n_step;
    logic [D_W-1:0]    r_drem, n_drem;
    logic [DV_W-1:0]   r_dv, n_dv;
    logic [Q_W-1:0]    r_q, n_q;
    logic              r_neg, n_neg;
    logic [VALUE_W-1:0] r_res_value, n_res_value;
    logic [1:0]        r_res_status, n_res_status;
    logic              r_out_v, n_out_v;
    logic [VALUE_W-1:0] r_out_value, n_out_value;
    logic [1:0]        r_out_status, n_out_status;

    // Accumulator memory.
    logic [ACC_W-1:0]  mem [DIMS];
    logic [ACC_W-1:0]  r_rd_data;
    logic [ADDR_W-1:0] rd_addr, wa;
    logic [ACC_W-1:0]  wd;
    logic              we;

    // Weight pipeline.
    logic              issue;
    logic              r_p1_v, r_p2_v, r_p3_v, r_p4_v, r_p5_v, r_p6_v, r_p7_v, r_p8_v;
    logic [ADDR_W-1:0] r_p1_d, r_p2_d, r_p3_d, r_p4_d, r_p5_d, r_p6_d, r_p7_d, r_p8_d;
    logic [63:0]       r_p1_x, r_p2_lo, r_p3_y, r_p4_lo, r_p5_z;
    logic [31:0]       r_p2_hi, r_p4_hi;
    logic [FOLD_W-1:0] r_p6_r, r_p7_r;
    logic [FQ_W-1:0]   r_p7_q;
    logic signed [11:0] r_p8_w;
    logic              pipe_busy;

    logic [63:0] x0, m1, m2;
    logic [31:0] hi1, hi2;
    logic [2*FOLD_W-1:0] recip_prod;
    logic [FOLD_W-1:0]   fold_sub;
    logic [11:0]         wrem;
    logic signed [ACC_W:0] acc_sum;
    logic [ACC_W-1:0]    acc_sat;

    // Sum of squares.
    logic              sq_issue;
    logic              r_sq_v1, r_sq_v2;
    logic [SQ_W-1:0]   r_sq;
    logic signed [2*ACC_W-1:0] sq_full;

    // Root and division step signals.
    logic [RSH_W-1:0]  rem_sh, trial;
    logic              root_ge;
    logic [ROOT_W-1:0] root_next;
    logic [ACC_W-1:0]  mag;
    logic [D_W-1:0]    dvd;
    logic              div_ge;
    logic [Q_W-1:0]    q_next, q_clamp;
    logic              rd_fin;

    assign o_init_busy = r_init;
    assign pipe_busy = r_p1_v | r_p2_v | r_p3_v | r_p4_v | r_p5_v | r_p6_v | r_p7_v | r_p8_v;

    assign o_out.valid         = r_out_v;
    assign o_out.element_value = r_out_value;
    assign o_out.status        = r_out_status;

    // Pipeline stage logic.
    assign x0  = r_hash ^ {32'd0, r_dk};
    assign hi1 = r_p2_hi * MIX_C1;
    assign m1  = r_p2_lo + {hi1, 32'd0};
    assign hi2 = r_p4_hi * MIX_C2;
    assign m2  = r_p4_lo + {hi2, 32'd0};
    assign recip_prod = r_p6_r * RECIP;
    assign fold_sub   = r_p7_r - FOLD_W'(r_p7_q) * FOLD_W'(W_MOD);
    assign wrem = (fold_sub[11:0] >= 12'(W_MOD)) ? (fold_sub[11:0] - 12'(W_MOD))
                                                 : fold_sub[11:0];
    assign acc_sum = $signed({r_rd_data[ACC_W-1], r_rd_data})
                   + (ACC_W + 1)'(r_p8_w);
    always_comb begin
        if (acc_sum[ACC_W] != acc_sum[ACC_W-1]) begin
            acc_sat = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
    end

    assign sq_full = $signed(r_rd_data) * $signed(r_rd_data);

    assign rem_sh    = {r_rem, r_sh[SUM_W-1:SUM_W-2]};
    assign trial     = RSH_W'({r_root, 2'b01});
    assign root_ge   = (rem_sh >= trial);
    assign root_next = {r_root[ROOT_W-2:0], root_ge};

    assign mag = r_rd_data[ACC_W-1] ? (ACC_W'(0) - r_rd_data) : r_rd_data;
    assign dvd = D_W'({mag, 32'd0}) + D_W'(r_norm >> 1);
    assign div_ge  = (DV_W'(r_drem) >= r_dv);
    assign q_next  = {r_q[Q_W-2:0], div_ge};
    assign q_clamp = (q_next > Q_W'(Q_MAX)) ? Q_W'(Q_MAX) : q_next;
    assign rd_fin  = r_finished && !i_op.unfinish;

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_dk = r_dk;
        n_hash = r_hash;
        n_chain = r_chain;
        n_finished = r_finished;
        n_norm = r_norm;
        n_init = r_init;
        n_sum = r_sq_v2 ? (r_sum + SUM_W'(r_sq)) : r_sum;
        n_sh = r_sh;
        n_rem = r_rem;
        n_root = r_root;
        n_step = r_step;
        n_drem = r_drem;
        n_dv = r_dv;
        n_q = r_q;
        n_neg = r_neg;
        n_res_value = r_res_value;
        n_res_status = r_res_status;
        n_out_v = r_out_v && !o_out.ready;
        n_out_value = r_out_value;
        n_out_status = r_out_status;
        o_pop = 1'b0;
        issue = 1'b0;
        sq_issue = 1'b0;
        rd_addr = r_cnt[ADDR_W-1:0];
        we = 1'b0;
        wa = r_cnt[ADDR_W-1:0];
        wd = '0;
        unique case (r_state)
            BS_CLEAR: begin
                we = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIMS - 1)) begin
                    n_state = BS_IDLE;
                    n_init = 1'b0;
                end
            end
            BS_IDLE: begin
                rd_addr = i_op.index[ADDR_W-1:0];
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_cnt = '0;
                    n_dk = '0;
                    n_hash = i_op.hash;
                    unique case (i_op.kind)
                        OP_FLUSH: begin
                            n_finished = 1'b0;
                            n_chain = 1'b0;
                            n_state = BS_FLUSH;
                        end
                        OP_FINISH: begin
                            n_chain = 1'b1;
                            if (i_op.has_token) begin
                                n_state = BS_FLUSH;
                            end else begin
                                n_sum = '0;
                                n_state = BS_SUMSQ;
                            end
                        end
                        OP_CLEAR: begin
                            n_finished = 1'b0;
                            n_norm = '0;
                            n_state = BS_CLEAR;
                        end
                        OP_READ: begin
                            if (i_op.unfinish) begin
                                n_finished = 1'b0;
                            end
                            n_res_value = '0;
                            n_state = BS_OUT;
                            if (!rd_fin) begin
                                n_res_status = ST_STALE;
                            end else if (r_norm == '0) begin
                                n_res_status = ST_ZERO;
                            end else begin
                                n_res_status = ST_OK;
                                if ({1'b0, i_op.index} < (INDEX_W + 1)'(DIMS)) begin
                                    n_state = BS_RDMEM;
                                end
                            end
                        end
                        default: begin
                            n_state = BS_IDLE;
                        end
                    endcase
                end
            end
            BS_FLUSH: begin
                rd_addr = r_p7_d;
                we = r_p8_v;
                wa = r_p8_d;
                wd = acc_sat;
                if (r_cnt < CNT_W'(DIMS)) begin
                    issue = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                    n_dk = r_dk + DK_STEP;
                end else if (!pipe_busy) begin
                    n_cnt = '0;
                    if (r_chain) begin
                        n_sum = '0;
                        n_state = BS_SUMSQ;
                    end else begin
                        n_state = BS_IDLE;
                    end
                end
            end
            BS_SUMSQ: begin
                if (r_cnt < CNT_W'(DIMS)) begin
                    sq_issue = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end else if (!r_sq_v1 && !r_sq_v2) begin
                    n_sh = r_sum;
                    n_rem = '0;
                    n_root = '0;
                    n_step = '0;
                    n_state = BS_ROOT;
                end
            end
            BS_ROOT: begin
                // One root bit per cycle, two radicand bits shifted in from the top.
                n_rem = root_ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
                n_root = root_next;
                n_sh = r_sh << 2;
                n_step = r_step + 1'b1;
                if (r_step == 6'(ROOT_STEPS - 1)) begin
                    n_norm = NORM_W'(root_next);
                    n_finished = 1'b1;
                    n_state = BS_IDLE;
                end
            end
            BS_RDMEM: begin
                n_neg = r_rd_data[ACC_W-1];
                if (CMP_W'(dvd) >= {r_norm, Q_W'(0)}) begin
                    n_res_value = r_rd_data[ACC_W-1] ? (VALUE_W'(0) - VALUE_W'(Q_MAX))
                                                     : VALUE_W'(Q_MAX);
                    n_state = BS_OUT;
                end else begin
                    n_drem = dvd;
                    n_dv = {r_norm, (Q_W - 1)'(0)};
                    n_q = '0;
                    n_step = '0;
                    n_state = BS_DIV;
                end
            end
            BS_DIV: begin
                n_drem = div_ge ? D_W'(DV_W'(r_drem) - r_dv) : r_drem;
                n_dv = r_dv >> 1;
                n_q = q_next;
                n_step = r_step + 1'b1;
                if (r_step == 6'(Q_W - 1)) begin
                    n_res_value = r_neg ? (VALUE_W'(0) - VALUE_W'(q_clamp)) : VALUE_W'(q_clamp);
                    n_state = BS_OUT;
                end
            end
            BS_OUT: begin
                if (!r_out_v || o_out.ready) begin
                    n_out_v = 1'b1;
                    n_out_value = r_res_value;
                    n_out_status = r_res_status;
                    n_state = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_p1_x  <= x0 ^ (x0 >> 16);
        r_p1_d  <= r_cnt[ADDR_W-1:0];
        r_p2_lo <= r_p1_x[31:0] * MIX_C1;
        r_p2_hi <= r_p1_x[63:32];
        r_p2_d  <= r_p1_d;
        r_p3_y  <= m1 ^ (m1 >> 13);
        r_p3_d  <= r_p2_d;
        r_p4_lo <= r_p3_y[31:0] * MIX_C2;
        r_p4_hi <= r_p3_y[63:32];
        r_p4_d  <= r_p3_d;
        r_p5_z  <= m2 ^ (m2 >> 16);
        r_p5_d  <= r_p4_d;
        r_p6_r  <= FOLD_W'(r_p5_z[15:0])
                 + FOLD_W'(r_p5_z[31:16]) * FOLD_W'(FOLD_1)
                 + FOLD_W'(r_p5_z[47:32]) * FOLD_W'(FOLD_2)
                 + FOLD_W'(r_p5_z[63:48]) * FOLD_W'(FOLD_3);
        r_p6_d  <= r_p5_d;
        r_p7_q  <= recip_prod[RECIP_SHIFT+FQ_W-1:RECIP_SHIFT];
        r_p7_r  <= r_p6_r;
        r_p7_d  <= r_p6_d;
        r_p8_w  <= $signed(wrem) - 12'sd1000;
        r_p8_d  <= r_p7_d;
        r_sq    <= SQ_W'(unsigned'(sq_full));
        r_sh    <= n_sh;
        r_rem   <= n_rem;
        r_root  <= n_root;
        r_drem  <= n_drem;
        r_dv    <= n_dv;
        r_q     <= n_q;
        r_neg   <= n_neg;
        r_dk    <= n_dk;
        r_hash  <= n_hash;
        r_sum   <= n_sum;
        r_res_value  <= n_res_value;
        r_res_status <= n_res_status;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= BS_CLEAR;
            r_cnt      <= '0;
            r_chain    <= 1'b0;
            r_finished <= 1'b0;
            r_norm     <= '0;
            r_init     <= 1'b1;
            r_step     <= '0;
            r_out_v    <= 1'b0;
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_p4_v <= 1'b0;
            r_p5_v <= 1'b0;
            r_p6_v <= 1'b0;
            r_p7_v <= 1'b0;
            r_p8_v <= 1'b0;
            r_sq_v1 <= 1'b0;
            r_sq_v2 <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_chain    <= n_chain;
            r_finished <= n_finished;
            r_norm     <= n_norm;
            r_init     <= n_init;
            r_step     <= n_step;
            r_out_v    <= n_out_v;
            r_p1_v <= issue;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            r_p4_v <= r_p3_v;
            r_p5_v <= r_p4_v;
            r_p6_v <= r_p5_v;
            r_p7_v <= r_p6_v;
            r_p8_v <= r_p7_v;
            r_sq_v1 <= sq_issue;
            r_sq_v2 <= r_sq_v1;
        end
    end

endmodule

// File: rtl/core/hashed_token_random_projection_core.sv
// A token flush sweeps all DIMS accumulators through the weight pipeline stages r_p1 to r_p8;
// finish adds a sum of squares and a bit-serial root. A read takes a memory read and an 18-step
// divider, which a saturated quotient skips. Letters are taken one per cycle unless the queue
// is full or the reset clear runs; the accumulator memory port sets one dimension per cycle.
// After reset a clearing pass zeroes the memory; no input transfer is taken.
// Reset is synchronous and active low; the clear command runs the same clearing pass.
module hashed_token_random_projection_core
    import hrp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    hrp_in_if.sink    i_in,
    hrp_out_if.source o_out
);

    logic q_push, q_full, q_pop, q_empty, init_busy;
    t_op  push_op, pop_op;

    hrp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .i_init_busy (init_busy),
        .o_push      (q_push),
        .o_op        (push_op)
    );

    hrp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (push_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_op    (pop_op),
        .o_empty (q_empty)
    );

    hrp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (pop_op),
        .i_empty     (q_empty),
        .o_pop       (q_pop),
        .o_init_busy (init_busy),
        .o_out       (o_out)
    );

endmodule
